/* rtl/sdb_pkg.sv */
// Shared types and constants for the stereo disparity back-projection block.
// No dependencies; imported by sdb_div and the top level.
package sdb_pkg;

  localparam int DenW      = 16;            // disparity width, Q8.8
  localparam int NumW      = 36;            // |offset| * baseline * 16
  localparam int DivStages = NumW;          // one quotient bit per stage
  localparam int NumLanes  = 3;             // X, Y and Z share one divisor

  localparam int unsigned LaneX = 0;
  localparam int unsigned LaneY = 1;
  localparam int unsigned LaneZ = 2;

  localparam logic [15:0] BaselineReset = 16'd7826;
  localparam logic [15:0] FocalReset    = 16'd4119;
  localparam logic [12:0] WidthReset    = 13'd640;
  localparam logic [12:0] HeightReset   = 13'd480;

  typedef enum logic [1:0] {
    RegBaseline = 2'd0,
    RegFocal    = 2'd1,
    RegWidth    = 2'd2,
    RegHeight   = 2'd3
  } reg_idx_e;

  typedef logic [NumW-1:0] num_t;

  // Sideband that rides along with each point through the divider.
  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic no_match;
    logic last;
  } sdb_tag_t;

endpackage

/* rtl/sdb_div.sv */
// Pipelined unsigned restoring divider, one quotient bit per stage, three lanes
// sharing one divisor. Depends on sdb_pkg.
module sdb_div
  import sdb_pkg::*;
(
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  sdb_tag_t                            in_tag_i,
  input  logic [DenW-1:0]                     in_den_i,
  input  num_t [NumLanes-1:0]                 in_num_i,
  output logic                                out_valid_o,
  output sdb_tag_t                            out_tag_o,
  output num_t [NumLanes-1:0]                 out_quo_o
);

  logic     [DivStages-1:0]                           valid_q;
  sdb_tag_t [DivStages-1:0]                           tag_q;
  logic     [DivStages-2:0][DenW-1:0]                 den_q;
  logic     [DivStages-2:0][NumLanes-1:0][DenW-1:0]   rem_q;
  num_t     [DivStages-1:0][NumLanes-1:0]             quo_q;

  for (genvar s = 0; s < DivStages; s++) begin : g_stage
    logic                               p_valid;
    sdb_tag_t                           p_tag;
    logic [DenW-1:0]                    p_den;
    logic [NumLanes-1:0][DenW-1:0]      p_rem;
    num_t [NumLanes-1:0]                p_quo;
    logic [NumLanes-1:0][DenW-1:0]      n_rem;
    num_t [NumLanes-1:0]                n_quo;

    if (s == 0) begin : g_first
      assign p_valid = in_valid_i;
      assign p_tag   = in_tag_i;
      assign p_den   = in_den_i;
      assign p_rem   = '0;
      assign p_quo   = in_num_i;
    end else begin : g_next
      assign p_valid = valid_q[s-1];
      assign p_tag   = tag_q[s-1];
      assign p_den   = den_q[s-1];
      assign p_rem   = rem_q[s-1];
      assign p_quo   = quo_q[s-1];
    end

    for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      logic [DenW:0]   shifted;
      logic [DenW+1:0] diff;
      // bring down the next numerator bit, try subtracting the divisor
      assign shifted  = {p_rem[l], p_quo[l][NumW-1]};
      assign diff     = {1'b0, shifted} - {2'b00, p_den};
      assign n_rem[l] = diff[DenW+1] ? shifted[DenW-1:0] : diff[DenW-1:0];
      assign n_quo[l] = {p_quo[l][NumW-2:0], ~diff[DenW+1]};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else begin
        valid_q[s] <= p_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (p_valid) begin
        tag_q[s] <= p_tag;
        quo_q[s] <= n_quo;
      end
    end

    // the last stage hands on neither remainder nor divisor
    if (s < DivStages - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (p_valid) begin
          rem_q[s] <= n_rem;
          den_q[s] <= p_den;
        end
      end
    end
  end

  assign out_valid_o = valid_q[DivStages-1];
  assign out_tag_o   = tag_q[DivStages-1];
  assign out_quo_o   = quo_q[DivStages-1];

endmodule

/* rtl/stereo_disparity_backprojection.sv */
// Stereo back-projection: pixel position + disparity -> X/Y/Z in 2^-16 m.
// A point passes through the offset and multiply stages, 36 divider stages and
// the output register in that order; one point per cycle, busy never rises.
// Reset clears the pipeline valids and loads the register defaults. Uses
// sdb_pkg and sdb_div.
module stereo_disparity_backprojection
  import sdb_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         pixel_x_i,
  input  logic [15:0]         pixel_y_i,
  input  logic [15:0]         disparity_i,
  input  logic                last_in_i,
  // results
  output logic                result_valid_o,
  output logic signed [31:0]  world_x_o,
  output logic signed [31:0]  world_y_o,
  output logic [30:0]         world_z_o,
  output logic                point_valid_o,
  output logic                last_out_o,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // ---------------- configuration registers ----------------
  logic [15:0] baseline_q;
  logic [15:0] focal_q;
  logic [12:0] width_q;
  logic [12:0] height_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      baseline_q <= BaselineReset;
      focal_q    <= FocalReset;
      width_q    <= WidthReset;
      height_q   <= HeightReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegBaseline: baseline_q <= (pwdata[15:0] != '0) ? pwdata[15:0] : BaselineReset;
        RegFocal:    focal_q    <= (pwdata[15:0] != '0) ? pwdata[15:0] : FocalReset;
        RegWidth:    width_q    <= pwdata[12:0];
        RegHeight:   height_q   <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      RegBaseline: prdata = {16'h0, baseline_q};
      RegFocal:    prdata = {16'h0, focal_q};
      RegWidth:    prdata = {19'h0, width_q};
      RegHeight:   prdata = {19'h0, height_q};
      default:     prdata = '0;
    endcase
  end

  // ---------------- stage 1: subtract image center ----------------
  logic               in_xfer;
  logic               s1_valid_q;
  logic signed [16:0] s1_xo_q, s1_yo_q;
  logic [DenW-1:0]    s1_den_q;
  logic               s1_last_q;

  assign busy    = 1'b0;
  assign in_xfer = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_xfer;
    end
  end

  // center in Q.4 is size * 8
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_xo_q   <= $signed({1'b0, pixel_x_i} - {1'b0, width_q, 3'b000});
      s1_yo_q   <= $signed({1'b0, pixel_y_i} - {1'b0, height_q, 3'b000});
      s1_den_q  <= disparity_i;
      s1_last_q <= last_in_i;
    end
  end

  // ---------------- stage 2: products ----------------
  logic [15:0]         mag_x, mag_y;
  logic                s2_valid_q;
  logic [31:0]         s2_mul_x_q, s2_mul_y_q, s2_mul_z_q;
  sdb_tag_t            s2_tag_q;
  logic [DenW-1:0]     s2_den_q;

  // negative offsets reach at most 65528, so 16 magnitude bits suffice
  assign mag_x = s1_xo_q[16] ? 16'(-s1_xo_q) : 16'(s1_xo_q);
  assign mag_y = s1_yo_q[16] ? 16'(-s1_yo_q) : 16'(s1_yo_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_mul_x_q        <= 32'(mag_x) * 32'(baseline_q);
      s2_mul_y_q        <= 32'(mag_y) * 32'(baseline_q);
      s2_mul_z_q        <= 32'(baseline_q) * 32'(focal_q);
      s2_tag_q.neg_x    <= s1_xo_q[16];
      s2_tag_q.neg_y    <= s1_yo_q[16];
      s2_tag_q.no_match <= (s1_den_q == '0);
      s2_tag_q.last     <= s1_last_q;
      s2_den_q          <= s1_den_q;
    end
  end

  // ---------------- divider ----------------
  num_t [NumLanes-1:0] div_num;
  num_t [NumLanes-1:0] div_quo;
  logic                div_valid;
  sdb_tag_t            div_tag;

  assign div_num[LaneX] = {s2_mul_x_q, 4'b0000};
  assign div_num[LaneY] = {s2_mul_y_q, 4'b0000};
  assign div_num[LaneZ] = {s2_mul_z_q, 4'b0000};

  sdb_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s2_valid_q),
    .in_tag_i   (s2_tag_q),
    .in_den_i   (s2_den_q),
    .in_num_i   (div_num),
    .out_valid_o(div_valid),
    .out_tag_o  (div_tag),
    .out_quo_o  (div_quo)
  );

  // ---------------- output: sign, saturate, register ----------------
  function automatic logic [31:0] sat_signed(input logic neg, input num_t q);
    logic [31:0] r;
    if (!neg) begin
      r = (q > num_t'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
    end else begin
      r = (q > num_t'(32'h8000_0000)) ? 32'h8000_0000 : 32'(-q[31:0]);
    end
    return r;
  endfunction

  logic        res_valid_q;
  logic [31:0] res_x_q, res_y_q;
  logic [30:0] res_z_q;
  logic        res_pv_q, res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_valid) begin
      res_last_q <= div_tag.last;
      if (div_tag.no_match) begin
        res_x_q  <= '0;
        res_y_q  <= '0;
        res_z_q  <= '0;
        res_pv_q <= 1'b0;
      end else begin
        res_x_q  <= sat_signed(div_tag.neg_x, div_quo[LaneX]);
        res_y_q  <= sat_signed(div_tag.neg_y, div_quo[LaneY]);
        res_z_q  <= (div_quo[LaneZ] > num_t'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF
                                                              : div_quo[LaneZ][30:0];
        res_pv_q <= 1'b1;
      end
    end
  end

  assign result_valid_o = res_valid_q;
  assign world_x_o      = $signed(res_x_q);
  assign world_y_o      = $signed(res_y_q);
  assign world_z_o      = res_z_q;
  assign point_valid_o  = res_pv_q;
  assign last_out_o     = res_last_q;

endmodule
